### sv/i2ctch_pkg.sv
// Shared types and constants for the serial-bus target command handler.
`timescale 1ns / 1ps

package i2ctch_pkg;

   // Store depths.
   localparam int RX_DEPTH = 2;
   localparam int TX_DEPTH = 4;

   // Index and count widths that follow from the depths.
   localparam int RX_IDX_W = $clog2(RX_DEPTH);
   localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
   localparam int TX_IDX_W = $clog2(TX_DEPTH);
   localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

   // Reply lengths of the read-back commands.
   localparam int ID_BYTES    = 4;
   localparam int TACHO_BYTES = 2;

   localparam logic [7:0] CMD_GET_ID    = 8'h01;
   localparam logic [7:0] CMD_SET_PWM   = 8'h02;
   localparam logic [7:0] CMD_GET_TACHO = 8'h03;

   typedef enum logic [1:0] {
      KIND_ADDR  = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_WRITE = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  write_byte;
      logic [15:0] tacho_value;
   } req_type;

   typedef struct packed {
      logic       ack;
      logic [7:0] read_byte;
      logic [7:0] fan_duty;
      logic       pwm_loaded;
   } rsp_type;

endpackage

### sv/i2c_target_command_handler_unit.sv
// Top level of the serial-bus target command handler.
`timescale 1ns / 1ps

// Port group   Direction  Handshake             Beat contents
// req_         in         req_valid/req_stall   event kind, written byte, tacho value
// rsp_         out        rsp_valid/rsp_stall   ack, read byte, PWM target, PWM loaded
// csr_         in         csr_wr_en             chip ID (32 bits), no read-back
//
// An event sits in the input register while the command logic computes its
// result, which loads into the result register at the edge that takes the event.
// A new event is accepted every cycle while the result side is not stalled; the
// rate is set by the single input register feeding the result register. A stalled
// result holds while one further event waits in the input register. Reset is
// synchronous and clears counts, reply length and position, PWM target and the chip ID.

module i2c_target_command_handler_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  i2ctch_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2ctch_pkg::rsp_type rsp_data,
   input  logic                csr_wr_en,
   input  logic [31:0]         csr_wr_data
);

   logic [31:0]         chip_id_ff;
   logic                ev_valid;
   logic                ev_take;
   i2ctch_pkg::req_type ev_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         chip_id_ff <= '0;
      end else if (csr_wr_en) begin
         chip_id_ff <= csr_wr_data;
      end
   end

   i2ctch_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .ev_valid  (ev_valid),
      .ev_data   (ev_data),
      .ev_take   (ev_take)
   );

   i2ctch_core u_core (
      .clock     (clock),
      .reset     (reset),
      .chip_id   (chip_id_ff),
      .ev_valid  (ev_valid),
      .ev_data   (ev_data),
      .ev_take   (ev_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### sv/i2ctch_in_stage.sv
// Input register that holds one bus event beat until the core takes it.
`timescale 1ns / 1ps

module i2ctch_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2ctch_pkg::req_type req_data,
   output logic              ev_valid,
   output i2ctch_pkg::req_type ev_data,
   input  logic              ev_take
);

   logic                valid_ff;
   logic                valid_in;
   i2ctch_pkg::req_type data_ff;
   i2ctch_pkg::req_type data_in;
   logic                req_fire;

   // A held beat that the core takes this cycle frees the register at once.
   assign req_stall = valid_ff && !ev_take;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_fire) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (ev_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign ev_valid = valid_ff;
   assign ev_data  = data_ff;

endmodule

### sv/i2ctch_core.sv
// Command state, event processing and the result register.
`timescale 1ns / 1ps

module i2ctch_core (
   input  logic                clock,
   input  logic                reset,
   input  logic [31:0]         chip_id,
   input  logic                ev_valid,
   input  i2ctch_pkg::req_type ev_data,
   output logic                ev_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output i2ctch_pkg::rsp_type rsp_data
);

   logic [7:0] rx_store_ff [i2ctch_pkg::RX_DEPTH];
   logic [7:0] rx_store_in [i2ctch_pkg::RX_DEPTH];
   logic [7:0] tx_store_ff [i2ctch_pkg::TX_DEPTH];
   logic [7:0] tx_store_in [i2ctch_pkg::TX_DEPTH];

   logic [i2ctch_pkg::RX_CNT_W-1:0] rx_count_ff, rx_count_in;
   logic [i2ctch_pkg::TX_CNT_W-1:0] tx_len_ff, tx_len_in;
   logic [i2ctch_pkg::TX_CNT_W-1:0] tx_pos_ff, tx_pos_in;
   logic [7:0]                      duty_ff, duty_in;

   logic                rsp_valid_ff, rsp_valid_in;
   i2ctch_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic advance;

   // The result register can load when empty or when its beat leaves now.
   assign advance = ev_valid && (!rsp_valid_ff || !rsp_stall);
   assign ev_take = advance;

   always_comb begin
      rx_store_in  = rx_store_ff;
      tx_store_in  = tx_store_ff;
      rx_count_in  = rx_count_ff;
      tx_len_in    = tx_len_ff;
      tx_pos_in    = tx_pos_ff;
      duty_in      = duty_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (advance) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.ack        = 1'b0;
         rsp_data_in.read_byte  = 8'd0;
         rsp_data_in.pwm_loaded = 1'b0;

         unique case (ev_data.kind)
            i2ctch_pkg::KIND_ADDR: begin
               tx_pos_in = '0;
            end
            i2ctch_pkg::KIND_STOP: begin
               if (rx_count_ff != '0) begin
                  unique case (rx_store_ff[0])
                     i2ctch_pkg::CMD_GET_ID: begin
                        for (int i = 0; i < i2ctch_pkg::ID_BYTES; i++) begin
                           tx_store_in[i] = chip_id[8*i +: 8];
                        end
                        tx_len_in = i2ctch_pkg::TX_CNT_W'(i2ctch_pkg::ID_BYTES);
                        tx_pos_in = '0;
                     end
                     i2ctch_pkg::CMD_SET_PWM: begin
                        // At least one data byte after the command byte; bytes past the store are dropped.
                        if (rx_count_ff == i2ctch_pkg::RX_CNT_W'(2)) begin
                           duty_in                = rx_store_ff[1];
                           rsp_data_in.pwm_loaded = 1'b1;
                        end
                     end
                     i2ctch_pkg::CMD_GET_TACHO: begin
                        for (int i = 0; i < i2ctch_pkg::TACHO_BYTES; i++) begin
                           tx_store_in[i] = ev_data.tacho_value[8*i +: 8];
                        end
                        tx_len_in = i2ctch_pkg::TX_CNT_W'(i2ctch_pkg::TACHO_BYTES);
                        tx_pos_in = '0;
                     end
                     default: begin
                        tx_len_in = '0;
                        tx_pos_in = '0;
                     end
                  endcase
               end
               rx_count_in = '0;
            end
            i2ctch_pkg::KIND_READ: begin
               if (tx_pos_ff < tx_len_ff) begin
                  rsp_data_in.read_byte =
                     tx_store_ff[tx_pos_ff[i2ctch_pkg::TX_IDX_W-1:0]];
                  rsp_data_in.ack = 1'b1;
                  tx_pos_in       = tx_pos_ff + 1'b1;
               end
            end
            i2ctch_pkg::KIND_WRITE: begin
               if (rx_count_ff < i2ctch_pkg::RX_CNT_W'(i2ctch_pkg::RX_DEPTH)) begin
                  rx_store_in[rx_count_ff[i2ctch_pkg::RX_IDX_W-1:0]] = ev_data.write_byte;
                  rx_count_in     = rx_count_ff + 1'b1;
                  rsp_data_in.ack = 1'b1;
               end
            end
            default: begin
            end
         endcase

         rsp_data_in.fan_duty = duty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff  <= '0;
         tx_len_ff    <= '0;
         tx_pos_ff    <= '0;
         duty_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_count_ff  <= rx_count_in;
         tx_len_ff    <= tx_len_in;
         tx_pos_ff    <= tx_pos_in;
         duty_ff      <= duty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_store_ff <= rx_store_in;
      tx_store_ff <= tx_store_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### test/i2c_target_command_handler_unit_tb.sv
// Self-checking testbench for the serial-bus target command handler.
`timescale 1ns / 1ps

module i2c_target_command_handler_unit_tb;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_EVENTS = 210;

   // Tracks the handler's receive and reply stores and predicts each result beat.
   class reply_tracker;
      logic [31:0]                     chip_id;
      logic [7:0]                      rx_store [i2ctch_pkg::RX_DEPTH];
      logic [i2ctch_pkg::RX_CNT_W-1:0] rx_count;
      logic [7:0]                      tx_store [i2ctch_pkg::TX_DEPTH];
      logic [i2ctch_pkg::TX_CNT_W-1:0] tx_len;
      logic [i2ctch_pkg::TX_CNT_W-1:0] tx_pos;
      logic [7:0]                      duty;
      i2ctch_pkg::rsp_type             expected_beats [$];
      int                              errors;

      function new();
         chip_id  = '0;
         rx_count = '0;
         tx_len   = '0;
         tx_pos   = '0;
         duty     = '0;
         errors   = 0;
      endfunction

      function void set_chip_id(logic [31:0] value);
         chip_id = value;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void load_reply(logic [31:0] value, int count);
         for (int i = 0; i < count; i++) tx_store[i] = value[8*i +: 8];
         tx_len = i2ctch_pkg::TX_CNT_W'(count);
         tx_pos = '0;
      endfunction

      function void note_event(i2ctch_pkg::req_type ev);
         i2ctch_pkg::rsp_type beat;
         beat = '0;
         case (ev.kind)
            i2ctch_pkg::KIND_ADDR: begin
               tx_pos = '0;
            end
            i2ctch_pkg::KIND_STOP: begin
               if (rx_count != 0) begin
                  case (rx_store[0])
                     i2ctch_pkg::CMD_GET_ID: load_reply(chip_id, i2ctch_pkg::ID_BYTES);
                     i2ctch_pkg::CMD_SET_PWM: begin
                        // At least one data byte must follow the command.
                        if (rx_count == 2) begin
                           duty = rx_store[1];
                           beat.pwm_loaded = 1'b1;
                        end
                     end
                     i2ctch_pkg::CMD_GET_TACHO:
                        load_reply({16'h0, ev.tacho_value}, i2ctch_pkg::TACHO_BYTES);
                     default: load_reply('0, 0);
                  endcase
               end
               rx_count = '0;
            end
            i2ctch_pkg::KIND_READ: begin
               if (tx_pos < tx_len) begin
                  beat.read_byte = tx_store[tx_pos[i2ctch_pkg::TX_IDX_W-1:0]];
                  beat.ack = 1'b1;
                  tx_pos++;
               end
            end
            default: begin
               if (rx_count < i2ctch_pkg::RX_DEPTH) begin
                  rx_store[rx_count[i2ctch_pkg::RX_IDX_W-1:0]] = ev.write_byte;
                  beat.ack = 1'b1;
                  rx_count++;
               end
            end
         endcase
         beat.fan_duty = duty;
         expected_beats.push_back(beat);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_beat(i2ctch_pkg::rsp_type got);
         i2ctch_pkg::rsp_type want;
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         compare_field("ack", 32'(want.ack), 32'(got.ack));
         compare_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
         compare_field("fan_duty", 32'(want.fan_duty), 32'(got.fan_duty));
         compare_field("pwm_loaded", 32'(want.pwm_loaded), 32'(got.pwm_loaded));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   i2ctch_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   i2ctch_pkg::rsp_type rsp_data;
   logic                csr_wr_en = 1'b0;
   logic [31:0]         csr_wr_data = '0;

   reply_tracker tracker;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int events_sent = 0;
   int cycle_count = 0;

   i2c_target_command_handler_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("i2c_target_command_handler_unit test failed");
         $finish;
      end
   end

   // Both channels are sampled here, before the block's own registers update.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tracker.note_event(req_data);
         if (rsp_valid && !rsp_stall) tracker.check_beat(rsp_data);
      end
   end

   always @(negedge clock) begin
      rsp_stall = !reset && ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_event(i2ctch_pkg::kind_type kind, logic [7:0] wbyte,
                             logic [15:0] tacho);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data.kind = kind;
      req_data.write_byte = wbyte;
      req_data.tacho_value = tacho;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      events_sent++;
   endtask

   task automatic send_random_event(i2ctch_pkg::kind_type kind);
      send_event(kind, 8'($urandom), 16'($urandom));
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      // The block holds at most two beats in flight past the last result.
      repeat (4) @(negedge clock);
   endtask

   task automatic write_chip_id(logic [31:0] value);
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      tracker.set_chip_id(value);
   endtask

   // Mostly a full command transfer followed by a read-back; sometimes pure noise.
   task automatic run_transaction();
      int nwrites;
      int nreads;
      logic [7:0] cmd;
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 4))
            send_random_event(i2ctch_pkg::kind_type'($urandom_range(0, 3)));
         return;
      end
      case ($urandom_range(0, 9))
         0, 1, 2: cmd = i2ctch_pkg::CMD_GET_ID;
         3, 4:    cmd = i2ctch_pkg::CMD_SET_PWM;
         5, 6:    cmd = i2ctch_pkg::CMD_GET_TACHO;
         default: cmd = 8'($urandom);
      endcase
      send_random_event(i2ctch_pkg::KIND_ADDR);
      nwrites = $urandom_range(0, 3);
      if (nwrites > 0) begin
         send_event(i2ctch_pkg::KIND_WRITE, cmd, 16'($urandom));
         for (int i = 1; i < nwrites; i++) send_random_event(i2ctch_pkg::KIND_WRITE);
      end
      send_random_event(i2ctch_pkg::KIND_STOP);
      if ($urandom_range(0, 3) != 0) begin
         send_random_event(i2ctch_pkg::KIND_ADDR);
         nreads = $urandom_range(0, 5);
         repeat (nreads) send_random_event(i2ctch_pkg::KIND_READ);
         if ($urandom_range(0, 1) != 0) send_random_event(i2ctch_pkg::KIND_STOP);
      end
   endtask

   initial begin
      logic [31:0] id_value;
      tracker = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, with the chip ID still at its reset value.
      send_idle_pct = 18;
      recv_stall_pct = 84;
      send_event(i2ctch_pkg::KIND_READ, 8'h00, 16'h0000);
      send_event(i2ctch_pkg::KIND_STOP, 8'hFF, 16'hFFFF);
      send_event(i2ctch_pkg::KIND_ADDR, 8'h00, 16'h0000);
      send_event(i2ctch_pkg::KIND_WRITE, i2ctch_pkg::CMD_GET_ID, 16'h0000);
      send_event(i2ctch_pkg::KIND_STOP, 8'h00, 16'h0000);
      repeat (5) send_event(i2ctch_pkg::KIND_READ, 8'hFF, 16'h0000);
      send_event(i2ctch_pkg::KIND_ADDR, 8'h00, 16'hFFFF);
      send_event(i2ctch_pkg::KIND_READ, 8'h00, 16'h0000);
      send_event(i2ctch_pkg::KIND_WRITE, i2ctch_pkg::CMD_SET_PWM, 16'h0000);
      send_event(i2ctch_pkg::KIND_WRITE, 8'hFF, 16'h0000);
      send_event(i2ctch_pkg::KIND_WRITE, 8'h77, 16'h0000);
      send_event(i2ctch_pkg::KIND_STOP, 8'h00, 16'h0000);
      send_event(i2ctch_pkg::KIND_WRITE, i2ctch_pkg::CMD_SET_PWM, 16'h0000);
      send_event(i2ctch_pkg::KIND_STOP, 8'h00, 16'h0000);
      send_event(i2ctch_pkg::KIND_WRITE, i2ctch_pkg::CMD_GET_TACHO, 16'h0000);
      send_event(i2ctch_pkg::KIND_STOP, 8'h00, 16'hFFFF);
      repeat (3) send_event(i2ctch_pkg::KIND_READ, 8'h00, 16'h0000);
      send_event(i2ctch_pkg::KIND_WRITE, 8'h00, 16'h0000);
      send_event(i2ctch_pkg::KIND_STOP, 8'h00, 16'h0000);
      send_event(i2ctch_pkg::KIND_READ, 8'h00, 16'h0000);

      // Random part: three idling profiles, two chip ID settings each.
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 18;
               recv_stall_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_stall_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int s = 0; s < 2; s++) begin
            case (2 * p + s)
               0:       id_value = 32'hFFFF_FFFF;
               1:       id_value = 32'h0000_0000;
               default: id_value = $urandom;
            endcase
            drain_results();
            write_chip_id(id_value);
            events_sent = 0;
            while (events_sent < PHASE_EVENTS) run_transaction();
         end
      end

      drain_results();
      repeat (10) @(negedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("i2c_target_command_handler_unit test passed");
      end else begin
         $display("i2c_target_command_handler_unit test failed");
      end
      $finish;
   end

endmodule
